/* rtl/core/lze_pkg.sv */
package lze_pkg;

	// Default block limits.
	localparam int unsigned MAX_LITERALS_DEF  = 48;
	localparam int unsigned MAX_MATCH_LEN_DEF = 1023;

	// Field widths of the stream items.
	localparam int unsigned LEN_W   = 10;
	localparam int unsigned DIST_W  = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned IN_TDATA_W = 40;

	// LZ4 coding constants.
	localparam logic [LEN_W-1:0]  MIN_MATCH   = 10'd4;
	localparam logic [LEN_W-1:0]  NIBBLE_MAX  = 10'd15;
	localparam logic [LEN_W-1:0]  RUN_CODE    = 10'd255;
	localparam logic [BYTE_W-1:0] TOKEN_LIT_F = 8'hF0;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_TOKEN,
		ST_LIT_EXT,
		ST_LITS,
		ST_OFF_LO,
		ST_OFF_HI,
		ST_MATCH_EXT,
		ST_FAULT
	} lze_state_t;

	// Source of the byte that goes into the output register.
	typedef enum logic [2:0] {
		SEL_TOKEN,
		SEL_LIT_EXT,
		SEL_LIT,
		SEL_OFF_LO,
		SEL_OFF_HI,
		SEL_MATCH_EXT,
		SEL_FAULT
	} lze_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     eval;
		logic     emit;
		lze_sel_t sel;
		logic     last;
		logic     done;
	} lze_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic skip_active;
		logic is_literal;
		logic lit_full;
		logic bad_len;
		logic is_last;
		logic is_match;
		logic cnt_zero;
		logic cnt_ge15;
		logic lit_at_end;
		logic ml_ge15;
		logic ext_ge255;
		logic emit_ok;
	} lze_status_t;

endpackage

/* rtl/core/lze_ctrl.sv */
module lze_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lze_pkg::lze_status_t status,
	output lze_pkg::lze_cmd_t    cmd
);
	import lze_pkg::*;

	lze_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.sel  = SEL_TOKEN;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				priority if (status.skip_active) begin
					state_d = ST_IDLE;
				end else if (status.is_literal) begin
					if (status.lit_full) begin
						state_d = ST_FAULT;
					end else if (status.is_last) begin
						state_d = ST_TOKEN;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (status.bad_len) begin
					state_d = ST_FAULT;
				end else begin
					state_d = ST_TOKEN;
				end
			end
			ST_TOKEN: begin
				cmd.sel = SEL_TOKEN;
				if (status.emit_ok) begin
					cmd.emit = 1'b1;
					priority if (status.cnt_ge15) begin
						state_d = ST_LIT_EXT;
					end else if (!status.cnt_zero) begin
						state_d = ST_LITS;
					end else if (status.is_match) begin
						state_d = ST_OFF_LO;
					end else begin
						cmd.last = 1'b1;
						cmd.done = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_LIT_EXT: begin
				cmd.sel = SEL_LIT_EXT;
				if (status.emit_ok) begin
					cmd.emit = 1'b1;
					state_d  = ST_LITS;
				end
			end
			ST_LITS: begin
				cmd.sel = SEL_LIT;
				if (status.emit_ok) begin
					cmd.emit = 1'b1;
					if (status.lit_at_end) begin
						if (status.is_match) begin
							state_d = ST_OFF_LO;
						end else begin
							cmd.last = 1'b1;
							cmd.done = 1'b1;
							state_d  = ST_IDLE;
						end
					end
				end
			end
			ST_OFF_LO: begin
				cmd.sel = SEL_OFF_LO;
				if (status.emit_ok) begin
					cmd.emit = 1'b1;
					state_d  = ST_OFF_HI;
				end
			end
			ST_OFF_HI: begin
				cmd.sel = SEL_OFF_HI;
				if (status.emit_ok) begin
					cmd.emit = 1'b1;
					if (status.ml_ge15) begin
						state_d = ST_MATCH_EXT;
					end else begin
						cmd.last = 1'b1;
						cmd.done = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_MATCH_EXT: begin
				cmd.sel = SEL_MATCH_EXT;
				if (status.emit_ok) begin
					cmd.emit = 1'b1;
					if (!status.ext_ge255) begin
						cmd.last = 1'b1;
						cmd.done = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_FAULT: begin
				cmd.sel = SEL_FAULT;
				if (status.emit_ok) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/lze_dp.sv */
module lze_dp #(
	parameter int unsigned MAX_LITERALS  = lze_pkg::MAX_LITERALS_DEF,
	parameter int unsigned MAX_MATCH_LEN = lze_pkg::MAX_MATCH_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lze_pkg::LEN_W-1:0]   in_len,
	input  logic [lze_pkg::DIST_W-1:0]  in_dist,
	input  logic [lze_pkg::BYTE_W-1:0]  in_lit,
	input  logic                        in_last,
	input  lze_pkg::lze_cmd_t           cmd,
	output lze_pkg::lze_status_t        status,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lze_pkg::BYTE_W-1:0]  out_byte,
	output logic                        out_last,
	output logic                        out_fault
);
	import lze_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_LITERALS);
	localparam int unsigned CNT_W = $clog2(MAX_LITERALS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LITERALS);
	localparam logic [CNT_W-1:0] CNT_15  = CNT_W'(15);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_MATCH_LEN);

	// Captured input item.
	logic [LEN_W-1:0]  len_q;
	logic [DIST_W-1:0] dist_q;
	logic [BYTE_W-1:0] lit_q;
	logic              last_q;

	// Block state.
	logic [LEN_W-1:0]  skip_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [LEN_W-1:0]  ml_q;
	logic [LEN_W-1:0]  ext_q;

	// Literal buffer with a registered read port.
	logic [BYTE_W-1:0] lit_mem [MAX_LITERALS];
	logic [BYTE_W-1:0] rd_q;
	logic [IDX_W-1:0]  rd_addr;

	// Output register.
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              out_fault_q;

	logic [LEN_W-1:0]  len_sat;
	logic [LEN_W-1:0]  ml_c;
	logic [3:0]        nib;
	logic [BYTE_W-1:0] byte_c;
	logic              lit_adv;
	logic              lit_wr;

	// Decode of the captured item.
	always_comb begin
		len_sat = (len_q > LEN_MAX) ? LEN_MAX : len_q;
		ml_c    = len_sat - MIN_MATCH;
		nib     = (ml_q < NIBBLE_MAX) ? ml_q[3:0] : 4'hF;
		if (!status.is_match) begin
			nib = 4'h0;
		end
	end

	always_comb begin
		status.skip_active = (skip_q != '0);
		status.is_literal  = (len_q <= LEN_W'(1));
		status.lit_full    = (cnt_q >= CNT_MAX);
		status.bad_len     = (len_q < MIN_MATCH);
		status.is_last     = last_q;
		status.is_match    = (len_q >= MIN_MATCH);
		status.cnt_zero    = (cnt_q == '0);
		status.cnt_ge15    = (cnt_q >= CNT_15);
		status.lit_at_end  = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
		status.ml_ge15     = (ml_q >= NIBBLE_MAX);
		status.ext_ge255   = (ext_q >= RUN_CODE);
		status.emit_ok     = !out_valid_q || out_ready;
	end

	// Byte selection for the next transfer.
	always_comb begin
		unique case (cmd.sel)
			SEL_TOKEN: begin
				if (status.cnt_ge15) begin
					byte_c = TOKEN_LIT_F | {4'h0, nib};
				end else begin
					byte_c = {cnt_q[3:0], nib};
				end
			end
			SEL_LIT_EXT:   byte_c = BYTE_W'(cnt_q) - BYTE_W'(15);
			SEL_LIT:       byte_c = rd_q;
			SEL_OFF_LO:    byte_c = dist_q[7:0];
			SEL_OFF_HI:    byte_c = dist_q[15:8];
			SEL_MATCH_EXT: byte_c = status.ext_ge255 ? RUN_CODE[7:0] : ext_q[7:0];
			SEL_FAULT:     byte_c = '0;
			default:       byte_c = '0;
		endcase
	end

	assign lit_adv = cmd.emit && (cmd.sel == SEL_LIT) && !status.lit_at_end;
	assign lit_wr  = cmd.eval && !status.skip_active && status.is_literal && !status.lit_full;
	assign rd_addr = lit_adv ? (idx_q + IDX_W'(1)) : idx_q;

	// Item capture on an input transfer.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			len_q  <= in_len;
			dist_q <= in_dist;
			lit_q  <= in_lit;
			last_q <= in_last;
		end
	end

	// Literal buffer write and read.
	always_ff @(posedge clk) begin
		if (lit_wr) begin
			lit_mem[cnt_q[IDX_W-1:0]] <= lit_q;
		end
		rd_q <= lit_mem[rd_addr];
	end

	// Skip, literal count and emission counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
			ml_q   <= '0;
			ext_q  <= '0;
		end else begin
			if (cmd.eval) begin
				idx_q <= '0;
				priority if (status.skip_active) begin
					skip_q <= last_q ? '0 : skip_q - LEN_W'(1);
				end else if (status.is_literal) begin
					cnt_q <= status.lit_full ? '0 : cnt_q + CNT_W'(1);
				end else if (status.bad_len) begin
					cnt_q <= '0;
				end else begin
					skip_q <= last_q ? '0 : len_sat - LEN_W'(1);
					ml_q   <= ml_c;
					ext_q  <= ml_c - NIBBLE_MAX;
				end
			end
			if (lit_adv) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.emit && (cmd.sel == SEL_MATCH_EXT) && status.ext_ge255) begin
				ext_q <= ext_q - RUN_CODE;
			end
			if (cmd.done) begin
				cnt_q <= '0;
			end
		end
	end

	// Output register: loads on emit, drains on a completed transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q  <= byte_c;
			out_last_q  <= cmd.last;
			out_fault_q <= (cmd.sel == SEL_FAULT);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_fault = out_fault_q;

endmodule

/* rtl/core/lz4_sequence_encoder.sv */
// Channel   | Direction | Payload
// s_axis    | in        | tdata: match_length, match_distance, literal_byte; tlast: last_position
// m_axis    | out       | tdata: out_byte; tlast: run_end; tuser: fault
//
// Each item is first transferred and then used to update the skip counter and
// the literal buffer. An item that closes a sequence then emits its bytes,
// read from the literal buffer one entry a cycle while the output accepts them.
// A stalled output holds the byte in the output register and pauses emission.
// Reset clears the skip counter, the literal count and the output register.
module lz4_sequence_encoder #(
	parameter int unsigned MAX_LITERALS  = lze_pkg::MAX_LITERALS_DEF,
	parameter int unsigned MAX_MATCH_LEN = lze_pkg::MAX_MATCH_LEN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [9:0] match_length, [25:10] match_distance, [33:26] literal_byte, [39:34] zero
	input  logic [lze_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [7:0] out_byte
	output logic [lze_pkg::BYTE_W-1:0]       m_axis_tdata,
	output logic                             m_axis_tlast,
	// [0] fault
	output logic                             m_axis_tuser
);
	import lze_pkg::*;

	lze_cmd_t    cmd;
	lze_status_t status;

	// Sequencing of one item.
	lze_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Literal buffer, counters and output register.
	lze_dp #(
		.MAX_LITERALS  (MAX_LITERALS),
		.MAX_MATCH_LEN (MAX_MATCH_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_len    (s_axis_tdata[9:0]),
		.in_dist   (s_axis_tdata[25:10]),
		.in_lit    (s_axis_tdata[33:26]),
		.in_last   (s_axis_tlast),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_fault (m_axis_tuser)
	);

endmodule
